@@ src/fsmgr_pkg.sv @@
// Shared types and constants for the flash segment manager.
// Used by flash_segment_manager_greedy_gc; no dependencies.
`default_nettype none
package fsmgr_pkg;

	localparam int NUM_SEGMENTS       = 64;
	localparam int SEG_W              = 6;
	localparam int PAGES_PER_SEGMENT  = 256;
	localparam int BM_WORD_W          = 64;
	localparam int BM_WORDS           = 1024;
	localparam int BM_AW              = 10;
	localparam int WORDS_PER_SEG_W    = 4;
	localparam int CNT_W              = 11;
	localparam int PAGE_CNT_W         = 9;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

	// operation codes
	typedef enum logic [3:0] {
		OP_GET_SEG   = 4'd0,
		OP_PICK_SEG  = 4'd1,
		OP_ALLOC_PG  = 4'd2,
		OP_PEEK_PG   = 4'd3,
		OP_SET       = 4'd4,
		OP_CLEAR     = 4'd5,
		OP_QUERY     = 4'd6,
		OP_VICTIM    = 4'd7,
		OP_TRIM      = 4'd8,
		OP_ACTIVATE  = 4'd9,
		OP_COUNTERS  = 4'd10,
		OP_COUNT_INV = 4'd11
	} op_t;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_SEG_FULL  = 2'd2;
	localparam logic [1:0] ST_NO_VICTIM = 2'd3;

	localparam logic [1:0] TYPE_ACTIVE = 2'd2;

	// per-segment record held in the segment memory
	typedef struct packed {
		logic                  active;
		logic [PAGE_CNT_W-1:0] pages;
		logic [CNT_W-1:0]      vcnt;
		logic [CNT_W-1:0]      icnt;
	} seg_entry_t;

endpackage
`default_nettype wire

@@ src/flash_segment_manager_greedy_gc.sv @@
// Flash segment manager top level: free FIFO, segment records, piece bitmap.
// Depends on fsmgr_pkg and fsmgr_ram.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, operation, seg_type,        | request
//          | segment, piece_address                          |
//  out     | out_valid, out_stall, status, result_segment,   | result
//          | page_address, bit_result, valid_count, ...      |
//
// One transaction at a time. Get seg also marks the segment active for the active type.
// Victim and count-invalid scan the 64 segment records through the memory read port;
// pick walks the free FIFO and also marks the segment active for the active type;
// trim clears 16 bitmap words. The next request is taken in the cycle after the
// result is registered. After reset a clearing pass wipes the 1024 bitmap words
// before the first request is taken. A stalled result waits in the output
// register while the next request is already accepted.
`default_nettype none
module flash_segment_manager_greedy_gc (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  operation,
	input  wire logic [1:0]  seg_type,
	input  wire logic [5:0]  segment,
	input  wire logic [15:0] piece_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [5:0]       result_segment,
	output logic [13:0]      page_address,
	output logic             bit_result,
	output logic [10:0]      valid_count,
	output logic [10:0]      invalid_count,
	output logic             fully_invalid,
	output logic [6:0]       free_segments,
	output logic             gc_needed,
	output logic [14:0]      free_pages,
	output logic [6:0]       invalid_segments
);

	typedef enum logic [9:0] {
		S_CLR    = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_ISSUE  = 10'b0000000100,
		S_EXEC   = 10'b0000001000,
		S_PSCAN  = 10'b0000010000,
		S_SSCAN  = 10'b0000100000,
		S_ACT_RD = 10'b0001000000,
		S_ACT_WR = 10'b0010000000,
		S_TRIM   = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	localparam int SW = fsmgr_pkg::SEG_W;
	localparam int CW = fsmgr_pkg::CNT_W;
	localparam int PAGE_CNT_W_L = fsmgr_pkg::PAGE_CNT_W;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		return (c == fsmgr_pkg::COUNT_MAX) ? c : c + 11'd1;
	endfunction

	state_t state_q;

	// latched request
	fsmgr_pkg::op_t op_q;
	logic [1:0]     type_q;
	logic [SW-1:0]  seg_q;
	logic [15:0]    pa_q;

	// FIFO bookkeeping
	logic [SW-1:0] head_q;
	logic [6:0]    count_q;

	// clearing pass, scans, trim
	logic [fsmgr_pkg::BM_AW-1:0]           clr_q;
	logic [6:0]                            idx_q;
	logic [6:0]                            n_q;
	logic                                  vld_s1;
	logic [SW-1:0]                         idx_s1;
	logic                                  found_q;
	fsmgr_pkg::seg_entry_t                 best_q;
	logic [SW-1:0]                         best_idx_q;
	logic [6:0]                            inv_cnt_q;
	logic [fsmgr_pkg::WORDS_PER_SEG_W-1:0] k_q;
	logic [SW-1:0]                         act_seg_q;

	// result being built
	logic [1:0]    res_status_q;
	logic [SW-1:0] res_seg_q;
	logic [13:0]   res_page_q;
	logic          res_bit_q;
	logic [CW-1:0] res_v_q;
	logic [CW-1:0] res_i_q;
	logic          res_all_q;
	logic [14:0]   res_fp_q;
	logic [6:0]    res_invseg_q;

	// memory ports
	logic                               bm_we;
	logic [fsmgr_pkg::BM_AW-1:0]        bm_waddr;
	logic [fsmgr_pkg::BM_WORD_W-1:0]    bm_wdata;
	logic [fsmgr_pkg::BM_AW-1:0]        bm_raddr;
	logic [fsmgr_pkg::BM_WORD_W-1:0]    bm_rdata;
	logic                               seg_we;
	logic [SW-1:0]                      seg_waddr;
	fsmgr_pkg::seg_entry_t              seg_wdata;
	logic [SW-1:0]                      seg_raddr;
	logic [$bits(fsmgr_pkg::seg_entry_t)-1:0] seg_rdata;
	logic                               fifo_we;
	logic [SW-1:0]                      fifo_waddr;
	logic [SW-1:0]                      fifo_wdata;
	logic [SW-1:0]                      fifo_raddr;
	logic [SW-1:0]                      fifo_rdata;

	fsmgr_pkg::seg_entry_t           seg_e;
	logic                            bit_old;
	logic [fsmgr_pkg::BM_WORD_W-1:0] bm_new;
	logic [CW-1:0]                   v_new;
	logic [CW-1:0]                   i_new;
	logic                            seg_full;
	logic [PAGE_CNT_W_L-1:0]         rem;
	logic                            scan_done;
	logic                            pick_done;
	logic                            accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	fsmgr_ram #(.WIDTH(fsmgr_pkg::BM_WORD_W), .DEPTH(fsmgr_pkg::BM_WORDS)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	fsmgr_ram #(.WIDTH($bits(fsmgr_pkg::seg_entry_t)), .DEPTH(fsmgr_pkg::NUM_SEGMENTS)) u_segs (
		.clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
		.raddr(seg_raddr), .rdata(seg_rdata)
	);

	fsmgr_ram #(.WIDTH(SW), .DEPTH(fsmgr_pkg::NUM_SEGMENTS)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
		.raddr(fifo_raddr), .rdata(fifo_rdata)
	);

	// read addresses
	assign bm_raddr   = pa_q[15:6];
	assign fifo_raddr = (state_q == S_PSCAN) ? head_q + idx_q[SW-1:0] : head_q;
	always_comb begin
		if (state_q == S_SSCAN) begin
			seg_raddr = idx_q[SW-1:0];
		end else if (state_q == S_ACT_RD) begin
			seg_raddr = act_seg_q;
		end else if (op_q == fsmgr_pkg::OP_SET || op_q == fsmgr_pkg::OP_CLEAR ||
			     op_q == fsmgr_pkg::OP_QUERY) begin
			seg_raddr = pa_q[15:10];
		end else begin
			seg_raddr = seg_q;
		end
	end

	// bit and counter update for set / clear / query
	assign seg_e   = fsmgr_pkg::seg_entry_t'(seg_rdata);
	assign bit_old = bm_rdata[pa_q[5:0]];
	always_comb begin
		bm_new = bm_rdata;
		v_new  = seg_e.vcnt;
		i_new  = seg_e.icnt;
		if (op_q == fsmgr_pkg::OP_SET) begin
			bm_new[pa_q[5:0]] = 1'b1;
			v_new = sat_inc(seg_e.vcnt);
		end else if (op_q == fsmgr_pkg::OP_CLEAR) begin
			bm_new[pa_q[5:0]] = 1'b0;
			i_new = sat_inc(seg_e.icnt);
		end
	end

	assign seg_full  = (seg_e.pages >= PAGE_CNT_W_L'(fsmgr_pkg::PAGES_PER_SEGMENT));
	assign rem       = seg_full ? '0 :
			   PAGE_CNT_W_L'(fsmgr_pkg::PAGES_PER_SEGMENT) - seg_e.pages;
	assign scan_done = (idx_q == 7'(fsmgr_pkg::NUM_SEGMENTS)) && !vld_s1;
	assign pick_done = (idx_q == count_q) && !vld_s1;

	// memory writes
	always_comb begin
		bm_we      = 1'b0;
		bm_waddr   = pa_q[15:6];
		bm_wdata   = bm_new;
		seg_we     = 1'b0;
		seg_waddr  = seg_raddr;
		seg_wdata  = seg_e;
		fifo_we    = 1'b0;
		fifo_waddr = head_q + n_q[SW-1:0];
		fifo_wdata = fifo_rdata;
		unique case (state_q)
			S_CLR: begin
				bm_we      = 1'b1;
				bm_waddr   = clr_q;
				bm_wdata   = '0;
				seg_we     = (clr_q[fsmgr_pkg::BM_AW-1:SW] == '0);
				seg_waddr  = clr_q[SW-1:0];
				seg_wdata  = '0;
				fifo_we    = seg_we;
				fifo_waddr = clr_q[SW-1:0];
				fifo_wdata = clr_q[SW-1:0];
			end
			S_EXEC: begin
				case (op_q)
					fsmgr_pkg::OP_ALLOC_PG: begin
						seg_we = !seg_full;
						seg_wdata.pages = seg_e.pages + 9'd1;
					end
					fsmgr_pkg::OP_SET, fsmgr_pkg::OP_CLEAR: begin
						bm_we = 1'b1;
						seg_we = 1'b1;
						seg_wdata.vcnt = v_new;
						seg_wdata.icnt = i_new;
					end
					fsmgr_pkg::OP_ACTIVATE: begin
						seg_we = 1'b1;
						seg_wdata.active = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_PSCAN: begin
				fifo_we = vld_s1 && (fifo_rdata != seg_q);
			end
			S_SSCAN: begin
				seg_we    = scan_done && found_q && (op_q == fsmgr_pkg::OP_VICTIM);
				seg_waddr = best_idx_q;
				seg_wdata = best_q;
				seg_wdata.active = 1'b0;
			end
			S_ACT_WR: begin
				seg_we    = 1'b1;
				seg_waddr = act_seg_q;
				seg_wdata.active = 1'b1;
			end
			S_TRIM: begin
				bm_we      = 1'b1;
				bm_waddr   = {seg_q, k_q};
				bm_wdata   = '0;
				seg_we     = (k_q == '0);
				seg_waddr  = seg_q;
				seg_wdata  = '0;
				fifo_we    = (k_q == '0) && (count_q != 7'(fsmgr_pkg::NUM_SEGMENTS));
				fifo_waddr = head_q + count_q[SW-1:0];
				fifo_wdata = seg_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			op_q         <= fsmgr_pkg::OP_GET_SEG;
			type_q       <= '0;
			seg_q        <= '0;
			pa_q         <= '0;
			head_q       <= '0;
			count_q      <= 7'(fsmgr_pkg::NUM_SEGMENTS);
			clr_q        <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_idx_q   <= '0;
			inv_cnt_q    <= '0;
			k_q          <= '0;
			act_seg_q    <= '0;
			res_status_q <= '0;
			res_seg_q    <= '0;
			res_page_q   <= '0;
			res_bit_q    <= 1'b0;
			res_v_q      <= '0;
			res_i_q      <= '0;
			res_all_q    <= 1'b0;
			res_fp_q     <= '0;
			res_invseg_q <= '0;
			out_valid        <= 1'b0;
			status           <= '0;
			result_segment   <= '0;
			page_address     <= '0;
			bit_result       <= 1'b0;
			valid_count      <= '0;
			invalid_count    <= '0;
			fully_invalid    <= 1'b0;
			free_segments    <= '0;
			gc_needed        <= 1'b0;
			free_pages       <= '0;
			invalid_segments <= '0;
		end else begin
			// result taken; the response state reloads it itself
			if (out_valid && !out_stall && state_q != S_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 10'd1;
					if (clr_q == 10'(fsmgr_pkg::BM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q         <= fsmgr_pkg::op_t'(operation);
						type_q       <= seg_type;
						seg_q        <= segment;
						pa_q         <= piece_address;
						res_status_q <= fsmgr_pkg::ST_OK;
						res_seg_q    <= '0;
						res_page_q   <= '0;
						res_bit_q    <= 1'b0;
						res_v_q      <= '0;
						res_i_q      <= '0;
						res_all_q    <= 1'b0;
						res_fp_q     <= '0;
						res_invseg_q <= '0;
						state_q      <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
					idx_q   <= '0;
					n_q     <= '0;
					vld_s1  <= 1'b0;
					found_q <= 1'b0;
					inv_cnt_q <= '0;
					k_q     <= '0;
					case (op_q)
						fsmgr_pkg::OP_GET_SEG: begin
							if (count_q == '0) begin
								res_status_q <= fsmgr_pkg::ST_NO_FREE;
							end else begin
								res_seg_q <= fifo_rdata;
								head_q    <= head_q + 6'd1;
								count_q   <= count_q - 7'd1;
								act_seg_q <= fifo_rdata;
								if (type_q == fsmgr_pkg::TYPE_ACTIVE) begin
									state_q <= S_ACT_RD;
								end
							end
						end
						fsmgr_pkg::OP_PICK_SEG: begin
							res_seg_q <= seg_q;
							state_q   <= S_PSCAN;
						end
						fsmgr_pkg::OP_ALLOC_PG, fsmgr_pkg::OP_PEEK_PG: begin
							res_seg_q <= seg_q;
							if (seg_full) begin
								res_status_q <= fsmgr_pkg::ST_SEG_FULL;
							end else begin
								res_page_q <= {seg_q, seg_e.pages[7:0]};
							end
						end
						fsmgr_pkg::OP_SET, fsmgr_pkg::OP_CLEAR, fsmgr_pkg::OP_QUERY: begin
							res_bit_q <= (op_q == fsmgr_pkg::OP_SET) ? !bit_old : bit_old;
							res_seg_q <= pa_q[15:10];
							res_v_q   <= v_new;
							res_i_q   <= i_new;
						end
						fsmgr_pkg::OP_VICTIM, fsmgr_pkg::OP_COUNT_INV: begin
							state_q <= S_SSCAN;
						end
						fsmgr_pkg::OP_TRIM: begin
							res_seg_q <= seg_q;
							state_q   <= S_TRIM;
						end
						fsmgr_pkg::OP_ACTIVATE: begin
							res_seg_q <= seg_q;
						end
						fsmgr_pkg::OP_COUNTERS: begin
							res_seg_q <= seg_q;
							res_v_q   <= seg_e.vcnt;
							res_i_q   <= seg_e.icnt;
							res_fp_q  <= {count_q, 8'b0} + 15'(rem);
						end
						default: begin
						end
					endcase
				end
				// walk the FIFO, keeping every entry but the picked segment
				S_PSCAN: begin
					vld_s1 <= (idx_q != count_q);
					if (idx_q != count_q) begin
						idx_q <= idx_q + 7'd1;
					end
					if (vld_s1 && (fifo_rdata != seg_q)) begin
						n_q <= n_q + 7'd1;
					end
					if (pick_done) begin
						count_q   <= n_q;
						act_seg_q <= seg_q;
						state_q   <= (type_q == fsmgr_pkg::TYPE_ACTIVE) ? S_ACT_RD : S_RESP;
					end
				end
				// scan all segment records: victim choice or invalid count
				S_SSCAN: begin
					vld_s1 <= (idx_q != 7'(fsmgr_pkg::NUM_SEGMENTS));
					idx_s1 <= idx_q[SW-1:0];
					if (idx_q != 7'(fsmgr_pkg::NUM_SEGMENTS)) begin
						idx_q <= idx_q + 7'd1;
					end
					if (vld_s1) begin
						if (op_q == fsmgr_pkg::OP_VICTIM) begin
							if (seg_e.active && (!found_q || seg_e.icnt > best_q.icnt)) begin
								best_q     <= seg_e;
								best_idx_q <= idx_s1;
								found_q    <= 1'b1;
							end
						end else if (seg_e.vcnt != '0 && seg_e.vcnt == seg_e.icnt) begin
							inv_cnt_q <= inv_cnt_q + 7'd1;
						end
					end
					if (scan_done) begin
						state_q <= S_RESP;
						if (op_q == fsmgr_pkg::OP_VICTIM) begin
							if (found_q) begin
								res_seg_q <= best_idx_q;
								res_v_q   <= best_q.vcnt;
								res_i_q   <= best_q.icnt;
								res_all_q <= (best_q.vcnt == best_q.icnt);
							end else begin
								res_status_q <= fsmgr_pkg::ST_NO_VICTIM;
							end
						end else begin
							res_invseg_q <= inv_cnt_q;
						end
					end
				end
				S_ACT_RD: begin
					state_q <= S_ACT_WR;
				end
				S_ACT_WR: begin
					state_q <= S_RESP;
				end
				// wipe the segment's bitmap words, re-enqueue on the first
				S_TRIM: begin
					k_q <= k_q + 4'd1;
					if (k_q == '0 && count_q != 7'(fsmgr_pkg::NUM_SEGMENTS)) begin
						count_q <= count_q + 7'd1;
					end
					if (k_q == '1) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid || !out_stall) begin
						out_valid        <= 1'b1;
						status           <= res_status_q;
						result_segment   <= res_seg_q;
						page_address     <= res_page_q;
						bit_result       <= res_bit_q;
						valid_count      <= res_v_q;
						invalid_count    <= res_i_q;
						fully_invalid    <= res_all_q;
						free_segments    <= count_q;
						gc_needed        <= (count_q == '0);
						free_pages       <= res_fp_q;
						invalid_segments <= res_invseg_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/fsmgr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module fsmgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
